// ----- rtl/assert_macros.svh -----
// assertion macros used by the top level rtl file of the keypoint heat map renderer
// no dependencies; include guarded
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, checked on every rising edge out of reset
`define ASSERT_NXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/kdhr_pkg.sv -----
// shared types, constants and tables of the keypoint heat map renderer
// no dependencies; used by kdhr_gauss and the top level
`timescale 1ns / 1ps
`default_nettype none

package kdhr_pkg;

	// default parameter values
	localparam int MAX_RADIUS_DEF = 3;
	localparam int COORD_BITS_DEF = 12;

	// field widths
	localparam int CRD_W   = 13;
	localparam int MAP_W   = 12;
	localparam int PIX_W   = 12;
	localparam int VAL_W   = 16;
	localparam int MEAN_W  = 7;
	localparam int SCALE_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BINARY_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAUSS_MEAN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAUSS_SCALE = 2'd2;
	localparam logic [SCALE_W-1:0]   GAUSS_SCALE_RST = 16'd14564;

	// fixed point constants
	localparam logic [VAL_W-1:0] Q15_ONE   = 16'd32768;
	localparam logic [30:0]      ONE_Q30   = 31'h4000_0000;
	localparam logic [15:0]      LOG2E_Q15 = 16'd47274;
	localparam logic [29:0]      LN2_Q30   = 30'd744261118;
	localparam logic [2:0]       HORNER_TERMS = 3'd6;

	// request from the scan sequencer to the weight unit
	typedef struct packed {
		logic              start;
		logic signed [2:0] dx;
		logic signed [2:0] dy;
	} gauss_req_t;

	// answer of the weight unit
	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] value;
	} gauss_rsp_t;

	// ceil(2^32 / k): exact quotient of a 30-bit value by k from the upper product word
	function automatic logic [31:0] kdhr_recip(input logic [2:0] k);
		logic [31:0] r;
		case (k)
			3'd2:    r = 32'h8000_0000;
			3'd3:    r = 32'd1431655766;
			3'd4:    r = 32'h4000_0000;
			3'd5:    r = 32'd858993460;
			3'd6:    r = 32'd715827883;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/kdhr_mul.sv -----
// shared 32 x 32 unsigned multiplier with a registered product
// no dependencies; instantiated by kdhr_gauss
`timescale 1ns / 1ps
`default_nettype none

module kdhr_mul (
	input  wire logic        clk,
	input  wire logic [31:0] op_a,
	input  wire logic [31:0] op_b,
	output logic      [63:0] prod_q
);

	// one product per cycle, result valid the cycle after the operands
	always_ff @(posedge clk) begin
		prod_q <= 64'(op_a) * 64'(op_b);
	end

endmodule

`default_nettype wire

// ----- rtl/kdhr_gauss.sv -----
// gaussian weight unit: sequencer around one shared multiplier
// depends on kdhr_pkg and kdhr_mul
`timescale 1ns / 1ps
`default_nettype none

module kdhr_gauss
	import kdhr_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic signed [MEAN_W-1:0]  gauss_mean,
	input  wire logic        [SCALE_W-1:0] gauss_scale,
	input  wire gauss_req_t                req,
	output gauss_rsp_t                     rsp
);

	typedef enum logic [3:0] {
		G_IDLE, G_SQA, G_SQB, G_SUM, G_EXP, G_LOG, G_LN, G_U,
		G_HMUL, G_HDIV, G_HSUB, G_FIN, G_DONE
	} gstate_t;

	gstate_t          state_q;
	logic [6:0]       am_q;
	logic [6:0]       bm_q;
	logic [14:0]      s_q;
	logic [3:0]       n_q;
	logic [29:0]      u_q;
	logic [30:0]      p_q;
	logic [2:0]       k_q;
	logic [VAL_W-1:0] value_q;

	logic [31:0]       op_a;
	logic [31:0]       op_b;
	logic [63:0]       prod_q;
	logic signed [7:0] a_s;
	logic signed [7:0] b_s;
	logic [4:0]        sh_w;
	logic [31:0]       rnd_sum;

	// offsets in q4.4 relative to the mean
	assign a_s = $signed({req.dx[2], req.dx, 4'b0000}) - $signed({gauss_mean[6], gauss_mean});
	assign b_s = $signed({req.dy[2], req.dy, 4'b0000}) - $signed({gauss_mean[6], gauss_mean});

	// final rounding shift of exp(-frac) by the integer part of the exponent
	assign sh_w    = 5'd15 + 5'(n_q);
	assign rnd_sum = 32'(p_q) + (32'd1 << (sh_w - 5'd1));

	// operand select for the shared multiplier
	always_comb begin
		op_a = 32'd0;
		op_b = 32'd0;
		case (state_q)
			G_SQA: begin
				op_a = 32'(am_q);
				op_b = 32'(am_q);
			end
			G_SQB: begin
				op_a = 32'(bm_q);
				op_b = 32'(bm_q);
			end
			G_EXP: begin
				op_a = 32'(s_q);
				op_b = 32'(gauss_scale);
			end
			G_LOG: begin
				op_a = 32'(prod_q[30:8]);
				op_b = 32'(LOG2E_Q15);
			end
			G_LN: begin
				op_a = 32'(prod_q[30:15]);
				op_b = 32'(LN2_Q30);
			end
			G_HMUL: begin
				op_a = 32'(u_q);
				op_b = 32'(p_q);
			end
			G_HDIV: begin
				op_a = 32'(prod_q[59:30]);
				op_b = kdhr_recip(k_q);
			end
			default: begin
				op_a = 32'd0;
				op_b = 32'd0;
			end
		endcase
	end

	kdhr_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// sequencer: squares, exponent, log2 split, horner series, rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			am_q    <= '0;
			bm_q    <= '0;
			s_q     <= '0;
			n_q     <= '0;
			u_q     <= '0;
			p_q     <= '0;
			k_q     <= '0;
			value_q <= '0;
		end else begin
			unique case (state_q)
				G_IDLE: begin
					if (req.start) begin
						am_q    <= a_s[7] ? 7'(-a_s) : 7'(a_s);
						bm_q    <= b_s[7] ? 7'(-b_s) : 7'(b_s);
						state_q <= G_SQA;
					end
				end
				G_SQA: state_q <= G_SQB;
				G_SQB: begin
					s_q     <= prod_q[14:0];
					state_q <= G_SUM;
				end
				G_SUM: begin
					s_q     <= s_q + prod_q[14:0];
					state_q <= G_EXP;
				end
				G_EXP: state_q <= G_LOG;
				G_LOG: state_q <= G_LN;
				G_LN: begin
					// integer part of 16 or more underflows to zero
					if (prod_q[38:35] != 4'd0) begin
						value_q <= '0;
						state_q <= G_DONE;
					end else begin
						n_q     <= prod_q[34:31];
						state_q <= G_U;
					end
				end
				G_U: begin
					u_q     <= prod_q[45:16];
					p_q     <= ONE_Q30;
					k_q     <= HORNER_TERMS;
					state_q <= G_HMUL;
				end
				G_HMUL: state_q <= G_HDIV;
				G_HDIV: begin
					if (k_q == 3'd1) begin
						p_q     <= ONE_Q30 - {1'b0, prod_q[59:30]};
						state_q <= G_FIN;
					end else begin
						state_q <= G_HSUB;
					end
				end
				G_HSUB: begin
					p_q     <= ONE_Q30 - {1'b0, prod_q[61:32]};
					k_q     <= k_q - 3'd1;
					state_q <= G_HMUL;
				end
				G_FIN: begin
					value_q <= 16'(rnd_sum >> sh_w);
					state_q <= G_DONE;
				end
				G_DONE: state_q <= G_IDLE;
				default: state_q <= G_IDLE;
			endcase
		end
	end

	always_comb begin
		rsp.done  = (state_q == G_DONE);
		rsp.value = value_q;
	end

endmodule

`default_nettype wire

// ----- rtl/keypoint_disc_heatmap_render_core.sv -----
// Keypoint disc heat map renderer, top level.
// Slave stream s_* takes one keypoint per transaction; master stream m_* gives
// pixel writes, the final one with tlast set. Plain write port cfg_* sets
// binary_mode (index 0), gauss_mean (1) and gauss_scale (2); the user must
// write them only while idle, the block itself does not enforce it. A
// keypoint whose centre is off the map gives one mask-only transaction
// (tuser all zero, tlast set). Otherwise the disc offsets are scanned with dx
// outer and dy inner; each offset is tested in the scan state, an in-map
// pixel then goes to the store state, a gaussian pixel first through the
// weight unit, which runs every multiply through one shared 32 x 32
// multiplier. A full radius-3 disc has 49 offsets and 29 pixels. s_tready is
// high only while no keypoint is in work. Each pixel is held one step so that
// the last one can be flagged; a stalled receiver holds the output register
// and the scan waits for it, while a finished result may sit in the output
// register as the next keypoint is taken. Reset restores the register
// defaults and empties the block; there is no memory and no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module keypoint_disc_heatmap_render_core
	import kdhr_pkg::*;
#(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// slave stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// centre_x[12:0], centre_y[25:13], map_width[38:26], map_height[51:39],
	// disc_radius[53:52], map_id[65:54], zero fill[71:66]
	input  wire logic [71:0]          s_tdata,
	// master stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// out_map[11:0], pixel_x[23:12], pixel_y[35:24], pixel_value[51:36], zero fill[55:52]
	output logic [55:0]               m_tdata,
	// write_valid[0], mask_valid[1]
	output logic [1:0]                m_tuser,
	output logic                      m_tlast,
	// configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

	localparam int unsigned LIM = 1 << COORD_BITS;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CALC, S_STORE, S_FLUSH} state_t;

	// configuration registers
	logic                      binary_mode_q;
	logic signed [MEAN_W-1:0]  gauss_mean_q;
	logic        [SCALE_W-1:0] gauss_scale_q;

	// keypoint context
	state_t                   state_q;
	logic signed [CRD_W-1:0]  cx_q;
	logic signed [CRD_W-1:0]  cy_q;
	logic        [CRD_W-1:0]  w_q;
	logic        [CRD_W-1:0]  h_q;
	logic        [1:0]        r_q;
	logic        [MAP_W-1:0]  map_q;
	logic                     outside_q;
	logic signed [2:0]        dx_q;
	logic signed [2:0]        dy_q;
	logic        [VAL_W-1:0]  new_val_q;

	// held pixel and output register
	logic                     pend_vld_q;
	logic [PIX_W-1:0]         pend_x_q;
	logic [PIX_W-1:0]         pend_y_q;
	logic [VAL_W-1:0]         pend_val_q;
	logic                     m_valid_q;
	logic [MAP_W-1:0]         o_map_q;
	logic [PIX_W-1:0]         o_x_q;
	logic [PIX_W-1:0]         o_y_q;
	logic [VAL_W-1:0]         o_val_q;
	logic                     o_wv_q;
	logic                     o_mv_q;
	logic                     o_last_q;

	// input decode
	logic signed [CRD_W-1:0] in_cx;
	logic signed [CRD_W-1:0] in_cy;
	logic        [CRD_W-1:0] in_w;
	logic        [CRD_W-1:0] in_h;
	logic        [1:0]       in_r;
	logic        [CRD_W-1:0] in_w_sat;
	logic        [CRD_W-1:0] in_h_sat;
	logic        [1:0]       in_r_sat;
	logic signed [2:0]       in_r3;
	logic                    in_outside;

	// scan datapath
	logic signed [2:0]        r3;
	logic signed [CRD_W:0]    hx;
	logic signed [CRD_W:0]    hy;
	logic [1:0]               dx_mag;
	logic [1:0]               dy_mag;
	logic [4:0]               d2;
	logic [3:0]               r2;
	logic                     pix_ok;
	logic                     adv_last;
	logic signed [2:0]        dx_nxt;
	logic signed [2:0]        dy_nxt;
	logic                     out_free;
	logic                     o_load;
	gauss_req_t               g_req;
	gauss_rsp_t               g_rsp;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binary_mode_q <= 1'b0;
			gauss_mean_q  <= '0;
			gauss_scale_q <= GAUSS_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_BINARY_MODE: binary_mode_q <= cfg_wdata[0];
				CFG_GAUSS_MEAN:  gauss_mean_q  <= cfg_wdata[MEAN_W-1:0];
				CFG_GAUSS_SCALE: gauss_scale_q <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// input fields with size and radius saturation
	always_comb begin
		in_cx = s_tdata[12:0];
		in_cy = s_tdata[25:13];
		in_w  = s_tdata[38:26];
		in_h  = s_tdata[51:39];
		in_r  = s_tdata[53:52];
		in_w_sat = ({4'b0000, in_w} > 17'(LIM)) ? CRD_W'(LIM) : in_w;
		in_h_sat = ({4'b0000, in_h} > 17'(LIM)) ? CRD_W'(LIM) : in_h;
		in_r_sat = (in_r > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : in_r;
		in_r3    = $signed({1'b0, in_r_sat});
		in_outside = in_cx[CRD_W-1] || in_cy[CRD_W-1] ||
			({1'b0, in_cx[CRD_W-2:0]} >= in_w_sat) ||
			({1'b0, in_cy[CRD_W-2:0]} >= in_h_sat);
	end

	// current offset: map bounds and disc test
	always_comb begin
		r3     = $signed({1'b0, r_q});
		hx     = $signed({cx_q[CRD_W-1], cx_q}) + (CRD_W+1)'(dx_q);
		hy     = $signed({cy_q[CRD_W-1], cy_q}) + (CRD_W+1)'(dy_q);
		dx_mag = dx_q[2] ? 2'(-dx_q) : dx_q[1:0];
		dy_mag = dy_q[2] ? 2'(-dy_q) : dy_q[1:0];
		d2     = 5'({2'b00, dx_mag} * {2'b00, dx_mag}) + 5'({2'b00, dy_mag} * {2'b00, dy_mag});
		r2     = {2'b00, r_q} * {2'b00, r_q};
		pix_ok = !hx[CRD_W] && (hx[CRD_W-1:0] < w_q) &&
			!hy[CRD_W] && (hy[CRD_W-1:0] < h_q) && (d2 <= 5'(r2));
		adv_last = (dx_q == r3) && (dy_q == r3);
		dy_nxt   = (dy_q == r3) ? -r3 : dy_q + 3'sd1;
		dx_nxt   = (dy_q == r3) ? dx_q + 3'sd1 : dx_q;
		out_free = !m_valid_q || m_tready;
		o_load   = ((state_q == S_STORE) && pend_vld_q && out_free) ||
			((state_q == S_FLUSH) && out_free);
	end

	// weight unit request
	always_comb begin
		g_req.start = (state_q == S_SCAN) && pix_ok && !binary_mode_q;
		g_req.dx    = dx_q;
		g_req.dy    = dy_q;
	end

	kdhr_gauss u_gauss (
		.clk         (clk),
		.arst_n      (arst_n),
		.gauss_mean  (gauss_mean_q),
		.gauss_scale (gauss_scale_q),
		.req         (g_req),
		.rsp         (g_rsp)
	);

	// scan sequencer, held pixel and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cx_q       <= '0;
			cy_q       <= '0;
			w_q        <= '0;
			h_q        <= '0;
			r_q        <= '0;
			map_q      <= '0;
			outside_q  <= 1'b0;
			dx_q       <= '0;
			dy_q       <= '0;
			new_val_q  <= '0;
			pend_vld_q <= 1'b0;
			pend_x_q   <= '0;
			pend_y_q   <= '0;
			pend_val_q <= '0;
			m_valid_q  <= 1'b0;
			o_map_q    <= '0;
			o_x_q      <= '0;
			o_y_q      <= '0;
			o_val_q    <= '0;
			o_wv_q     <= 1'b0;
			o_mv_q     <= 1'b0;
			o_last_q   <= 1'b0;
		end else begin
			// output valid: set on a load, cleared once taken
			if (o_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cx_q      <= in_cx;
						cy_q      <= in_cy;
						w_q       <= in_w_sat;
						h_q       <= in_h_sat;
						r_q       <= in_r_sat;
						map_q     <= s_tdata[65:54];
						outside_q <= in_outside;
						dx_q      <= -in_r3;
						dy_q      <= -in_r3;
						state_q   <= in_outside ? S_FLUSH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (pix_ok) begin
						if (binary_mode_q) begin
							new_val_q <= Q15_ONE;
							state_q   <= S_STORE;
						end else begin
							state_q <= S_CALC;
						end
					end else if (adv_last) begin
						state_q <= S_FLUSH;
					end else begin
						dx_q <= dx_nxt;
						dy_q <= dy_nxt;
					end
				end
				S_CALC: begin
					if (g_rsp.done) begin
						new_val_q <= g_rsp.value;
						state_q   <= S_STORE;
					end
				end
				S_STORE: begin
					// release the previous pixel, it is not the last one
					if (!pend_vld_q || out_free) begin
						if (pend_vld_q) begin
							o_map_q   <= map_q;
							o_x_q     <= pend_x_q;
							o_y_q     <= pend_y_q;
							o_val_q   <= pend_val_q;
							o_wv_q    <= 1'b1;
							o_mv_q    <= 1'b1;
							o_last_q  <= 1'b0;
						end
						pend_vld_q <= 1'b1;
						pend_x_q   <= hx[PIX_W-1:0];
						pend_y_q   <= hy[PIX_W-1:0];
						pend_val_q <= new_val_q;
						if (adv_last) begin
							state_q <= S_FLUSH;
						end else begin
							dx_q    <= dx_nxt;
							dy_q    <= dy_nxt;
							state_q <= S_SCAN;
						end
					end
				end
				S_FLUSH: begin
					// final transaction of the keypoint
					if (out_free) begin
						o_map_q   <= map_q;
						o_last_q  <= 1'b1;
						if (outside_q) begin
							o_x_q   <= '0;
							o_y_q   <= '0;
							o_val_q <= '0;
							o_wv_q  <= 1'b0;
							o_mv_q  <= 1'b0;
						end else begin
							o_x_q   <= pend_x_q;
							o_y_q   <= pend_y_q;
							o_val_q <= pend_val_q;
							o_wv_q  <= 1'b1;
							o_mv_q  <= 1'b1;
						end
						pend_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// port drive
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, o_val_q, o_y_q, o_x_q, o_map_q};
	assign m_tuser  = {o_mv_q, o_wv_q};
	assign m_tlast  = o_last_q;

	// checks
	`ASSERT_IMP(a_idle_empty, clk, arst_n, s_tready, !pend_vld_q)
	`ASSERT_IMP(a_store_on_pixel, clk, arst_n, state_q == S_STORE, pix_ok)
	`ASSERT_IMP(a_mask_only_last, clk, arst_n, m_tvalid && !m_tuser[0], m_tlast)
	`ASSERT_NXT(a_busy_after_take, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire

// ----- dv/keypoint_disc_heatmap_render_core_tb.sv -----
// self-checking testbench for the keypoint disc heat map renderer
// predicts every pixel write from the keypoint and the register settings, checks the m_* stream
// depends on kdhr_pkg and keypoint_disc_heatmap_render_core
`timescale 1ns / 1ps

module keypoint_disc_heatmap_render_core_tb;
	import kdhr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// one keypoint as presented on the slave stream
	typedef struct {
		logic signed [CRD_W-1:0] centre_x;
		logic signed [CRD_W-1:0] centre_y;
		logic [CRD_W-1:0]        map_width;
		logic [CRD_W-1:0]        map_height;
		logic [1:0]              disc_radius;
		logic [MAP_W-1:0]        map_id;
	} keypoint_t;

	// one pixel write (or mask-only transaction) on the master stream
	typedef struct {
		logic [MAP_W-1:0] out_map;
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic [VAL_W-1:0] pixel_value;
		logic             write_valid;
		logic             mask_valid;
		logic             last;
	} pixel_write_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [71:0]          s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [55:0]          m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	keypoint_disc_heatmap_render_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// shadow copy of the register file
	logic                     binary_reg = 1'b0;
	logic signed [MEAN_W-1:0] mean_reg = '0;
	logic [SCALE_W-1:0]       scale_reg = GAUSS_SCALE_RST;

	keypoint_t    pending_keypoints[$];
	pixel_write_t expected_writes[$];
	keypoint_t    current_kp;
	pixel_write_t head_write;
	int           send_gap = 0;
	int           stall_left = 0;
	int           open_left = 0;
	int           mismatches = 0;
	logic         steady_phase = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	// gaussian weight of one disc offset, Q1.15
	function automatic logic [VAL_W-1:0] disc_weight(int dx, int dy);
		longint          a, b;
		longint unsigned s, e, y, n, f, u, p;
		int              k;
		a = dx * 16 - mean_reg;
		b = dy * 16 - mean_reg;
		s = a * a + b * b;
		e = (s * scale_reg) >> 8;
		y = e * LOG2E_Q15;
		n = y >> 31;
		if (n >= 16)
			return '0;
		f = (y >> 15) & 64'hFFFF;
		u = (f * LN2_Q30) >> 16;
		// exp(-u) by a six-term horner scheme in Q2.30
		p = ONE_Q30;
		for (k = 6; k >= 1; k--)
			p = ONE_Q30 - ((u * p) >> 30) / k;
		return VAL_W'((p + (64'd1 << (14 + n))) >> (15 + n));
	endfunction

	// expected writes of one keypoint, queued in output order
	function automatic void render_keypoint(keypoint_t kp);
		int           cx, cy, w, h, r, lim, dx, dy, hx, hy;
		pixel_write_t pw;
		pixel_write_t burst[$];
		cx = kp.centre_x;
		cy = kp.centre_y;
		lim = 1 << COORD_BITS_DEF;
		w = kp.map_width;
		h = kp.map_height;
		r = kp.disc_radius;
		if (w > lim)
			w = lim;
		if (h > lim)
			h = lim;
		if (r > MAX_RADIUS_DEF)
			r = MAX_RADIUS_DEF;
		pw.out_map = kp.map_id;
		// centre off the map: one mask-only transaction
		if (cx < 0 || cy < 0 || cx >= w || cy >= h) begin
			pw.pixel_x = '0;
			pw.pixel_y = '0;
			pw.pixel_value = '0;
			pw.write_valid = 1'b0;
			pw.mask_valid = 1'b0;
			pw.last = 1'b1;
			expected_writes.insert(expected_writes.size(), pw);
			return;
		end
		// dx outer, dy inner, clipped to the map and the disc
		for (dx = -r; dx <= r; dx++) begin
			hx = cx + dx;
			if (hx < 0 || hx >= w)
				continue;
			for (dy = -r; dy <= r; dy++) begin
				hy = cy + dy;
				if (hy < 0 || hy >= h || dx * dx + dy * dy > r * r)
					continue;
				pw.pixel_x = PIX_W'(hx);
				pw.pixel_y = PIX_W'(hy);
				pw.pixel_value = binary_reg ? Q15_ONE : disc_weight(dx, dy);
				pw.write_valid = 1'b1;
				pw.mask_valid = 1'b1;
				pw.last = 1'b0;
				burst.insert(burst.size(), pw);
			end
		end
		burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			expected_writes.insert(expected_writes.size(), burst[i]);
	endfunction

	function automatic keypoint_t make_kp(int cx, int cy, int w, int h, int r, int id);
		keypoint_t kp;
		kp.centre_x = CRD_W'(cx);
		kp.centre_y = CRD_W'(cy);
		kp.map_width = CRD_W'(w);
		kp.map_height = CRD_W'(h);
		kp.disc_radius = 2'(r);
		kp.map_id = MAP_W'(id);
		return kp;
	endfunction

	// append one keypoint to the stimulus queue
	function automatic void queue_kp(keypoint_t kp);
		pending_keypoints.insert(pending_keypoints.size(), kp);
	endfunction

	// mostly small maps with the centre inside, some large maps and some raw noise
	function automatic keypoint_t random_kp();
		int w, h, cx, cy, r, pick;
		pick = $urandom_range(0, 9);
		r = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
		if (pick == 0)
			return make_kp($urandom_range(0, 8191), $urandom_range(0, 8191),
				$urandom_range(0, 8191), $urandom_range(0, 8191),
				$urandom_range(0, 3), $urandom_range(0, 4095));
		if (pick == 1) begin
			w = $urandom_range(4000, 8191);
			h = $urandom_range(4000, 8191);
			cx = $urandom_range(0, 1) ? $urandom_range(4090, 4095) : $urandom_range(0, 4095);
			cy = $urandom_range(0, 1) ? $urandom_range(4090, 4095) : $urandom_range(0, 4095);
		end else begin
			w = $urandom_range(1, 64);
			h = $urandom_range(1, 64);
			cx = $urandom_range(0, w - 1);
			cy = $urandom_range(0, h - 1);
		end
		return make_kp(cx, cy, w, h, r, $urandom_range(0, 4095));
	endfunction

	task automatic queue_random(int count);
		repeat (count)
			queue_kp(random_kp());
	endtask

	// wait until the block has delivered everything it owes
	task automatic wait_drained();
		while (pending_keypoints.size() != 0 || s_tvalid || expected_writes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_BINARY_MODE: binary_reg = data[0];
			CFG_GAUSS_MEAN:  mean_reg = data[MEAN_W-1:0];
			CFG_GAUSS_SCALE: scale_reg = data;
			default: ;
		endcase
	endtask

	// all three registers, unused upper bits filled with noise
	task automatic set_render_mode(logic bin, logic [MEAN_W-1:0] mean, logic [SCALE_W-1:0] scale);
		write_reg(CFG_BINARY_MODE, {15'($urandom), bin});
		write_reg(CFG_GAUSS_MEAN, {9'($urandom), mean});
		write_reg(CFG_GAUSS_SCALE, scale);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void check_field(string name, int exp_v, int got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	// slave side: present queued keypoints, predict on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				render_keypoint(current_kp);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_keypoints.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!steady_phase && $urandom_range(0, 3) == 0) begin
					send_gap = $urandom_range(0, 15);
					s_tvalid <= 1'b0;
				end else begin
					current_kp = pending_keypoints.pop_front();
					s_tdata <= {6'd0, current_kp.map_id, current_kp.disc_radius,
						current_kp.map_height, current_kp.map_width,
						current_kp.centre_y, current_kp.centre_x};
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// master side: random stall bursts and open stretches, check each transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			open_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_writes.size() == 0) begin
					$error("unexpected transaction for map %0d", m_tdata[11:0]);
					mismatches++;
				end else begin
					head_write = expected_writes.pop_front();
					check_field("out_map", head_write.out_map, m_tdata[11:0]);
					check_field("pixel_x", head_write.pixel_x, m_tdata[23:12]);
					check_field("pixel_y", head_write.pixel_y, m_tdata[35:24]);
					check_field("pixel_value", head_write.pixel_value, m_tdata[51:36]);
					check_field("write_valid", head_write.write_valid, m_tuser[0]);
					check_field("mask_valid", head_write.mask_valid, m_tuser[1]);
					check_field("last", head_write.last, m_tlast);
				end
			end
			if (!steady_phase && stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (steady_phase || open_left > 0) begin
				if (open_left > 0)
					open_left--;
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 15);
				m_tready <= 1'b0;
			end else begin
				if ($urandom_range(0, 29) == 0)
					open_left = $urandom_range(50, 300);
				m_tready <= 1'b1;
			end
		end
	end

	// phases of stimulus with register changes in between
	initial begin
		// reset defaults: full discs, clipping at every border, off-map centres
		queue_kp(make_kp(10, 10, 32, 32, 3, 0));
		queue_kp(make_kp(10, 10, 32, 32, 2, 4095));
		queue_kp(make_kp(10, 10, 32, 32, 1, 1));
		queue_kp(make_kp(10, 10, 32, 32, 0, 2));
		queue_kp(make_kp(0, 0, 1, 1, 3, 3));
		queue_kp(make_kp(0, 0, 8, 8, 3, 2730));
		queue_kp(make_kp(4095, 4095, 4096, 4096, 3, 1365));
		queue_kp(make_kp(4095, 4095, 8191, 8191, 2, 7));
		queue_kp(make_kp(-1, 5, 16, 16, 1, 8));
		queue_kp(make_kp(5, -1, 16, 16, 1, 9));
		queue_kp(make_kp(16, 5, 16, 16, 1, 10));
		queue_kp(make_kp(5, 16, 16, 16, 1, 11));
		queue_kp(make_kp(0, 0, 0, 5, 1, 12));
		queue_kp(make_kp(0, 0, 5, 0, 1, 13));
		queue_kp(make_kp(-4096, -4096, 4096, 4096, 3, 14));
		queue_kp(make_kp(4095, 0, 4095, 1, 3, 15));
		queue_kp(make_kp(4094, 0, 4095, 1, 3, 16));
		queue_kp(make_kp(3, 3, 7, 7, 3, 17));
		queue_kp(make_kp(2, 1, 5, 3, 3, 18));
		queue_kp(make_kp(100, 200, 8191, 4096, 1, 19));
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_drained();

		// most negative mean, steepest fall-off
		set_render_mode(1'b0, 7'h40, 16'hFFFF);
		queue_random(20);
		wait_drained();

		// largest mean, flat weight
		set_render_mode(1'b0, 7'h3F, 16'h0000);
		queue_random(15);
		wait_drained();

		// binary discs; the spare index must change nothing
		set_render_mode(1'b1, 7'($urandom), 16'($urandom));
		write_reg(CFG_SPARE, 16'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
		queue_random(15);
		wait_drained();

		set_render_mode(1'b0, 7'($urandom), 16'($urandom));
		queue_random(20);
		wait_drained();

		// closing stretch with no idling on either side
		steady_phase = 1'b1;
		set_render_mode(1'b0, 7'($urandom), GAUSS_SCALE_RST);
		queue_random(20);
		wait_drained();

		repeat (1500) @(negedge clk);
		if (expected_writes.size() != 0) begin
			$error("%0d expected transactions never arrived", expected_writes.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("[keypoint_disc_heatmap_render_core] OK");
		else
			$display("[keypoint_disc_heatmap_render_core] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("[keypoint_disc_heatmap_render_core] ERROR");
		$finish;
	end

endmodule
